FILE: rtl/core/nrmc_pkg.sv
// Shared types and constants for the RMC time parser.
// Depends on nothing; every module of the block imports it.
package nrmc_pkg;

	localparam int HISTORY_DEPTH = 3;
	localparam int NUM_GROUPS    = 4;

	localparam logic [7:0] COMMA_CHAR  = 8'h2C;
	localparam logic [7:0] DASH_CHAR   = 8'h2D;
	localparam logic [7:0] DIGIT_ZERO  = 8'h30;
	localparam logic [7:0] DIGIT_NINE  = 8'h39;

	localparam logic [3:0] COUNT_MAX    = 4'd15;
	localparam logic [3:0] TIME_TOKEN   = 4'd2;
	localparam logic [3:0] STATUS_TOKEN = 4'd3;

	localparam logic [1:0] GRP_HOUR   = 2'd0;
	localparam logic [1:0] GRP_MINUTE = 2'd1;
	localparam logic [1:0] GRP_SECOND = 2'd2;
	localparam logic [1:0] GRP_MILLI  = 2'd3;

	typedef struct packed {
		logic [7:0] sentence_byte;
		logic       end_of_sentence;
	} byte_item_t;

	typedef struct packed {
		logic       accepted;
		logic [6:0] held_hour;
		logic [6:0] held_minute;
		logic [6:0] held_second;
		logic [9:0] held_millisecond;
		logic [7:0] fix_status;
	} result_item_t;

	// What the tokenizer knows about a sentence once its last byte is in.
	typedef struct packed {
		logic       time_seen;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [9:0] millisecond;
		logic [7:0] status;
	} sentence_sum_t;

endpackage

FILE: rtl/core/nrmc_tokenizer.sv
// Per-sentence tokenizer: comma splitting, time-group digit parsing, status capture.
// Depends on nrmc_pkg.
module nrmc_tokenizer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  nrmc_pkg::byte_item_t  item,
	output nrmc_pkg::sentence_sum_t summary
);
	import nrmc_pkg::*;

	logic [3:0] tok_q, tok_n;
	logic [3:0] chr_q, chr_n;
	logic       in_tok_q, in_tok_n;
	logic [9:0] dig_q [NUM_GROUPS];
	logic [9:0] dig_n [NUM_GROUPS];
	logic [NUM_GROUPS-1:0] stop_q, stop_n;
	logic       seen_q, seen_n;
	logic [7:0] stat_q, stat_n;

	logic [3:0] pos;
	logic       grp_hit;
	logic [1:0] grp_idx;
	logic       is_digit;
	logic [7:0] c;

	assign c        = item.sentence_byte;
	assign is_digit = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);

	// Map a position inside the time token to its digit group.
	always_comb begin
		grp_hit = 1'b1;
		grp_idx = GRP_HOUR;
		if (pos < 4'd2) begin
			grp_idx = GRP_HOUR;
		end else if (pos < 4'd4) begin
			grp_idx = GRP_MINUTE;
		end else if (pos < 4'd6) begin
			grp_idx = GRP_SECOND;
		end else if (pos >= 4'd7 && pos < 4'd10) begin
			grp_idx = GRP_MILLI;
		end else begin
			grp_hit = 1'b0;
		end
	end

	always_comb begin
		tok_n    = tok_q;
		chr_n    = chr_q;
		in_tok_n = in_tok_q;
		stop_n   = stop_q;
		seen_n   = seen_q;
		stat_n   = stat_q;
		pos      = chr_q;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			dig_n[g] = dig_q[g];
		end
		if (c == COMMA_CHAR) begin
			in_tok_n = 1'b0;
		end else begin
			if (!in_tok_q) begin
				in_tok_n = 1'b1;
				pos      = 4'd0;
				if (tok_q != COUNT_MAX) begin
					tok_n = tok_q + 4'd1;
				end
			end
			if (tok_n == TIME_TOKEN) begin
				seen_n = 1'b1;
				for (int g = 0; g < NUM_GROUPS; g++) begin
					if (grp_hit && grp_idx == 2'(g) && !stop_q[g]) begin
						if (is_digit) begin
							// d*10 + digit, kept to 10 bits
							dig_n[g] = {dig_q[g][6:0], 3'b000} + {dig_q[g][8:0], 1'b0}
								+ {6'd0, c[3:0]};
						end else begin
							stop_n[g] = 1'b1;
						end
					end
				end
			end else if (tok_n == STATUS_TOKEN && pos == 4'd0) begin
				stat_n = c;
			end
			chr_n = (pos == COUNT_MAX) ? pos : pos + 4'd1;
		end
	end

	assign summary.time_seen   = seen_n;
	assign summary.hour        = dig_n[GRP_HOUR][6:0];
	assign summary.minute      = dig_n[GRP_MINUTE][6:0];
	assign summary.second      = dig_n[GRP_SECOND][6:0];
	assign summary.millisecond = dig_n[GRP_MILLI];
	assign summary.status      = stat_n;

	// Clear per-sentence state after the last byte of a sentence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= '0;
			chr_q    <= '0;
			in_tok_q <= 1'b0;
			stop_q   <= '0;
			seen_q   <= 1'b0;
			stat_q   <= DASH_CHAR;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				dig_q[g] <= '0;
			end
		end else if (step) begin
			if (item.end_of_sentence) begin
				tok_q    <= '0;
				chr_q    <= '0;
				in_tok_q <= 1'b0;
				stop_q   <= '0;
				seen_q   <= 1'b0;
				stat_q   <= DASH_CHAR;
				for (int g = 0; g < NUM_GROUPS; g++) begin
					dig_q[g] <= '0;
				end
			end else begin
				tok_q    <= tok_n;
				chr_q    <= chr_n;
				in_tok_q <= in_tok_n;
				stop_q   <= stop_n;
				seen_q   <= seen_n;
				stat_q   <= stat_n;
				for (int g = 0; g < NUM_GROUPS; g++) begin
					dig_q[g] <= dig_n[g];
				end
			end
		end
	end

endmodule

FILE: rtl/core/nrmc_history.sv
// Hour/minute history check, latched time and the result register.
// Depends on nrmc_pkg.
module nrmc_history (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  nrmc_pkg::sentence_sum_t summary,
	input  logic                    result_stall,
	output logic                    result_valid,
	output nrmc_pkg::result_item_t  result_data
);
	import nrmc_pkg::*;

	logic [6:0] hist_h_q [HISTORY_DEPTH];
	logic [6:0] hist_m_q [HISTORY_DEPTH];
	logic [6:0] hist_h_n [HISTORY_DEPTH];
	logic [6:0] hist_m_n [HISTORY_DEPTH];
	logic [6:0] hour_q, minute_q, second_q;
	logic [9:0] milli_q;
	logic       same;
	logic       take;
	logic       valid_q;
	result_item_t res_n, res_q;

	always_comb begin
		hist_h_n[0] = summary.hour;
		hist_m_n[0] = summary.minute;
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			hist_h_n[i] = hist_h_q[i-1];
			hist_m_n[i] = hist_m_q[i-1];
		end
		same = 1'b1;
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			if (hist_h_n[i] != hist_h_n[0] || hist_m_n[i] != hist_m_n[0]) begin
				same = 1'b0;
			end
		end
	end

	assign take = summary.time_seen && same;

	always_comb begin
		res_n.accepted         = !summary.time_seen || same;
		res_n.held_hour        = take ? summary.hour        : hour_q;
		res_n.held_minute      = take ? summary.minute      : minute_q;
		res_n.held_second      = take ? summary.second      : second_q;
		res_n.held_millisecond = take ? summary.millisecond : milli_q;
		res_n.fix_status       = take ? summary.status      : DASH_CHAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_h_q[i] <= '0;
				hist_m_q[i] <= '0;
			end
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			milli_q  <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (load && summary.time_seen) begin
				for (int i = 0; i < HISTORY_DEPTH; i++) begin
					hist_h_q[i] <= hist_h_n[i];
					hist_m_q[i] <= hist_m_n[i];
				end
			end
			if (load && take) begin
				hour_q   <= summary.hour;
				minute_q <= summary.minute;
				second_q <= summary.second;
				milli_q  <= summary.millisecond;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_n;
		end
	end

	assign result_valid = valid_q;
	assign result_data  = res_q;

endmodule

FILE: rtl/core/nmea_rmc_time_parser.sv
// Top level of the RMC time parser: input register, tokenizer, history/result stage.
// Depends on nrmc_pkg, nrmc_tokenizer and nrmc_history.
//
//  channel   signals                                    direction
//  byte      byte_valid, byte_stall, byte_data          sentence characters in
//  result    result_valid, result_stall, result_data    one item per sentence out
//
// One byte per cycle while byte_stall is low: a byte sits in the input register while the
// tokenizer and history logic act on it; the end byte loads the result register,
// so each result passes the input register and then the result register.
// Reset clears the sentence state, history and latched time to zero, status to '-'.
// Only an end byte waits on a held result; other bytes keep flowing under result_stall.
module nmea_rmc_time_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  nrmc_pkg::byte_item_t   byte_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output nrmc_pkg::result_item_t result_data
);
	import nrmc_pkg::*;

	logic          valid_s1;
	byte_item_t    item_s1;
	logic          advance;
	logic          accept;
	sentence_sum_t summary;

	// Hold an end byte until the result register is free.
	assign advance    = valid_s1 && (!item_s1.end_of_sentence || !result_valid || !result_stall);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_data;
		end
	end

	nrmc_tokenizer u_tokenizer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.summary (summary)
	);

	nrmc_history u_history (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && item_s1.end_of_sentence),
		.summary      (summary),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

endmodule

FILE: sim/rmc_time_checker.sv
// Scoreboard for the RMC time parser: follows both channels, predicts each result item.
// Depends on nrmc_pkg for the item types and character constants.
module rmc_time_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	input  logic                   byte_stall,
	input  nrmc_pkg::byte_item_t   byte_data,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  nrmc_pkg::result_item_t result_data,
	output int                     fail_count,
	output int                     pending,
	output int                     results_seen,
	output int                     rejects_seen
);
	import nrmc_pkg::*;

	logic [3:0]   tok_count;
	logic [3:0]   tok_pos;
	logic         in_tok;
	logic         saw_time;
	logic [9:0]   grp_val     [NUM_GROUPS];
	logic         grp_done    [NUM_GROUPS];
	logic [7:0]   status_seen;
	logic [6:0]   hour_hist   [HISTORY_DEPTH];
	logic [6:0]   minute_hist [HISTORY_DEPTH];
	logic [6:0]   fix_hour;
	logic [6:0]   fix_minute;
	logic [6:0]   fix_second;
	logic [9:0]   fix_milli;
	result_item_t due_fixes [$];
	result_item_t want;

	// position inside the time token -> group, NUM_GROUPS where no group lies
	function automatic int group_at(input logic [3:0] p);
		if (p < 2) return GRP_HOUR;
		if (p < 4) return GRP_MINUTE;
		if (p < 6) return GRP_SECOND;
		if (p >= 7 && p < 10) return GRP_MILLI;
		return NUM_GROUPS;
	endfunction

	task automatic clear_line();
		tok_count   = '0;
		tok_pos     = '0;
		in_tok      = 1'b0;
		saw_time    = 1'b0;
		status_seen = DASH_CHAR;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_val[g]  = '0;
			grp_done[g] = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	task automatic parse_char(input logic [7:0] ch, input logic eos);
		int           g;
		logic         agree;
		result_item_t fix;
		if (ch == COMMA_CHAR) begin
			in_tok = 1'b0;
		end else begin
			if (!in_tok) begin
				in_tok  = 1'b1;
				tok_pos = '0;
				if (tok_count != COUNT_MAX) tok_count++;
			end
			if (tok_count == TIME_TOKEN) begin
				saw_time = 1'b1;
				g = group_at(tok_pos);
				if (g < NUM_GROUPS && !grp_done[g]) begin
					if (ch >= DIGIT_ZERO && ch <= DIGIT_NINE)
						grp_val[g] = 10'(int'(grp_val[g]) * 10 + int'(ch - DIGIT_ZERO));
					else
						grp_done[g] = 1'b1;
				end
			end else if (tok_count == STATUS_TOKEN && tok_pos == 0) begin
				status_seen = ch;
			end
			if (tok_pos != COUNT_MAX) tok_pos++;
		end
		if (!eos) return;

		fix.accepted   = 1'b1;
		fix.fix_status = DASH_CHAR;
		if (saw_time) begin
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
				hour_hist[i]   = hour_hist[i - 1];
				minute_hist[i] = minute_hist[i - 1];
			end
			hour_hist[0]   = grp_val[GRP_HOUR][6:0];
			minute_hist[0] = grp_val[GRP_MINUTE][6:0];
			agree = 1'b1;
			for (int i = 1; i < HISTORY_DEPTH; i++)
				if (hour_hist[i] != hour_hist[0] || minute_hist[i] != minute_hist[0])
					agree = 1'b0;
			if (agree) begin
				fix_hour       = hour_hist[0];
				fix_minute     = minute_hist[0];
				fix_second     = grp_val[GRP_SECOND][6:0];
				fix_milli      = grp_val[GRP_MILLI];
				fix.fix_status = status_seen;
			end else begin
				fix.accepted = 1'b0;
			end
		end
		fix.held_hour        = fix_hour;
		fix.held_minute      = fix_minute;
		fix.held_second      = fix_second;
		fix.held_millisecond = fix_milli;
		due_fixes.push_back(fix);
		clear_line();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hour_hist[i]   = '0;
				minute_hist[i] = '0;
			end
			fix_hour     = '0;
			fix_minute   = '0;
			fix_second   = '0;
			fix_milli    = '0;
			due_fixes.delete();
			fail_count   = 0;
			results_seen = 0;
			rejects_seen = 0;
		end else begin
			// compare first: a result leaving now never belongs to a byte arriving now
			if (result_valid && !result_stall) begin
				results_seen++;
				if (due_fixes.size() == 0) begin
					$error("result item arrived with no sentence pending");
					fail_count++;
				end else begin
					want = due_fixes.pop_front();
					if (!want.accepted) rejects_seen++;
					check_field("accepted", want.accepted, result_data.accepted);
					check_field("held_hour", want.held_hour, result_data.held_hour);
					check_field("held_minute", want.held_minute, result_data.held_minute);
					check_field("held_second", want.held_second, result_data.held_second);
					check_field("held_millisecond", want.held_millisecond,
						result_data.held_millisecond);
					check_field("fix_status", want.fix_status, result_data.fix_status);
				end
			end
			if (byte_valid && !byte_stall)
				parse_char(byte_data.sentence_byte, byte_data.end_of_sentence);
		end
		pending = due_fixes.size();
	end

endmodule

FILE: sim/tb_top.sv
// Top of the RMC time parser testbench: clock, reset, sentence stimulus and verdict.
// Depends on nrmc_pkg, the parser RTL and rmc_time_checker.
module tb_top;
	import nrmc_pkg::*;

	localparam int         ITEM_GOAL     = 950;
	localparam int         CYCLE_LIMIT   = 200_000;
	localparam int         DRAIN_CYCLES  = 20;
	localparam logic [7:0] STATUS_ACTIVE = 8'h41;
	localparam logic [7:0] STATUS_VOID   = 8'h56;

	logic         clk;
	logic         arst_n       = 1'b0;
	logic         byte_valid   = 1'b0;
	logic         byte_stall;
	byte_item_t   byte_data    = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_data;

	int fail_count;
	int pending;
	int results_seen;
	int rejects_seen;
	int cycle_count   = 0;
	int bytes_sent    = 0;
	int lines_sent    = 0;
	int send_idle_pct = 8;
	int rcv_stall_pct = 86;
	int lock_hour     = 0;
	int lock_minute   = 0;

	logic [7:0] line_buf [$];

	nmea_rmc_time_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	rmc_time_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.rejects_seen (rejects_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) result_stall <= ($urandom_range(0, 99) < rcv_stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** nmea_rmc_time_parser: FAILED **");
			$finish;
		end
	end

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic add_num(input int v, input int digits);
		int div;
		div = 1;
		repeat (digits - 1) div *= 10;
		for (; div > 0; div /= 10) line_buf.push_back(8'(DIGIT_ZERO + (v / div) % 10));
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_byte(input byte_item_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= item;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic ship_line();
		byte_item_t item;
		for (int i = 0; i < line_buf.size(); i++) begin
			item.sentence_byte   = line_buf[i];
			item.end_of_sentence = (i == line_buf.size() - 1);
			push_byte(item);
		end
		lines_sent++;
		line_buf.delete();
	endtask

	task automatic build_random_line();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			// well-formed sentence; hold hh:mm steady most of the time so the history agrees
			if ($urandom_range(0, 99) < 20) begin
				lock_hour   = $urandom_range(0, 99);
				lock_minute = $urandom_range(0, 99);
			end
			add_text("$GPRMC,");
			add_num(lock_hour, 2);
			add_num(lock_minute, 2);
			add_num($urandom_range(0, 99), 2);
			add_text(".");
			add_num($urandom_range(0, 999), 3);
			if ($urandom_range(0, 9) != 0) begin
				add_text(",");
				if ($urandom_range(0, 4) == 0)
					line_buf.push_back(8'($urandom_range(0, 255)));
				else
					line_buf.push_back($urandom_range(0, 1) ? STATUS_ACTIVE : STATUS_VOID);
			end
			if ($urandom_range(0, 1)) add_text(",4807.038,N");
			if ($urandom_range(0, 9) == 0)
				line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind < 85) begin
			// broken: stray commas, short or malformed time token
			repeat ($urandom_range(0, 2)) add_text(",");
			add_text("$GP");
			repeat ($urandom_range(1, 3)) add_text(",");
			repeat ($urandom_range(0, 12)) begin
				if ($urandom_range(0, 3) == 0)
					line_buf.push_back(8'($urandom_range(0, 255)));
				else
					line_buf.push_back(8'(DIGIT_ZERO + $urandom_range(0, 9)));
			end
			repeat ($urandom_range(0, 2)) add_text(",");
			repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 20)) begin
				if ($urandom_range(0, 3) == 0)
					line_buf.push_back(COMMA_CHAR);
				else
					line_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// lone zero byte: no time token at all
		line_buf.push_back(8'h00);
		ship_line();
		// collapsing commas, all-zero time matches the reset history, top status byte
		add_text(",,x,,0000,");
		line_buf.push_back(8'hFF);
		ship_line();
		// short time tokens break the history
		add_text("x,9959");
		ship_line();
		add_text("x,995");
		ship_line();

		while (bytes_sent < ITEM_GOAL) begin
			if (bytes_sent >= 2 * ITEM_GOAL / 3) begin
				send_idle_pct = 0;
				rcv_stall_pct = 0;
			end else if (bytes_sent >= ITEM_GOAL / 3) begin
				send_idle_pct = 86;
				rcv_stall_pct = 8;
			end
			build_random_line();
			ship_line();
		end
		byte_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Drove %0d bytes in %0d sentences under three idle/stall mixes",
			bytes_sent, lines_sent);
		$display("Checked %0d result items, %0d rejected by the hour/minute history",
			results_seen, rejects_seen);
		if (fail_count == 0 && pending == 0)
			$display("** nmea_rmc_time_parser: PASSED **");
		else
			$display("** nmea_rmc_time_parser: FAILED **");
		$finish;
	end

endmodule
